FILE: design/pdd_pkg.sv
// shared types, constants and arithmetic helpers of the pid differential drive block
`default_nettype none

package pdd_pkg;

	localparam int PWM_SLICES  = 32;
	localparam int SLICE_W     = $clog2(PWM_SLICES);
	localparam int DUTY_W      = 6;
	localparam int DUTY_MIN    = 1;
	localparam int DUTY_MAX    = 32;
	localparam int EFFORT_ONE  = 16384;
	localparam int ACC_W       = 40;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_PROP_GAIN   = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_INTEG_GAIN  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DERIV_GAIN  = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_RSTEER_GAIN = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_RBASE_GAIN  = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_LSTEER_GAIN = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_LBASE_GAIN  = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SPEED  = 4'd7;

	localparam logic signed [15:0] RST_PROP_GAIN   = 16'sd256;
	localparam logic signed [15:0] RST_INTEG_GAIN  = 16'sd0;
	localparam logic signed [15:0] RST_DERIV_GAIN  = 16'sd0;
	localparam logic signed [15:0] RST_RSTEER_GAIN = 16'sd2560;
	localparam logic signed [15:0] RST_RBASE_GAIN  = 16'sd256;
	localparam logic signed [15:0] RST_LSTEER_GAIN = 16'sd2560;
	localparam logic signed [15:0] RST_LBASE_GAIN  = 16'sd256;
	localparam logic [DUTY_W-1:0]  RST_BASE_SPEED  = 6'd18;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [15:0] error_sample;
		logic               sample_valid;
	} pdd_in_t;

	typedef struct packed {
		logic               right_drive;
		logic               left_drive;
		logic [DUTY_W-1:0]  right_level;
		logic [DUTY_W-1:0]  left_level;
		logic signed [15:0] effort;
	} pdd_out_t;

	typedef struct packed {
		logic signed [15:0] prop_gain;
		logic signed [15:0] integ_gain;
		logic signed [15:0] deriv_gain;
		logic signed [15:0] right_steer_gain;
		logic signed [15:0] right_base_gain;
		logic signed [15:0] left_steer_gain;
		logic signed [15:0] left_base_gain;
		logic [DUTY_W-1:0]  base_speed;
	} pdd_cfg_t;

	typedef struct packed {
		logic               is_tick;
		logic               shift;
		logic signed [15:0] error;
	} pdd_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pdd_qstat_t;

	function automatic logic signed [15:0] clamp_effort(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-9:0] q;
		begin
			q = acc[ACC_W-1:8];
			if (q > EFFORT_ONE) begin
				return 16'(EFFORT_ONE);
			end else if (q < -EFFORT_ONE) begin
				return 16'(-EFFORT_ONE);
			end
			return 16'(q);
		end
	endfunction

	function automatic logic [DUTY_W-1:0] make_duty(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-23:0] q;
		begin
			q = acc[ACC_W-1:22];
			if (q > DUTY_MAX) begin
				return DUTY_W'(DUTY_MAX);
			end else if (q < DUTY_MIN) begin
				return DUTY_W'(DUTY_MIN);
			end
			return DUTY_W'(q);
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/pdd_front.sv
// front end: input classification, queue push and configuration register file
`default_nettype none

module pdd_front (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  pdd_pkg::pdd_in_t                   in_data,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [pdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire  [pdd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  pdd_pkg::pdd_qstat_t                q_stat,
	output logic                               push,
	output pdd_pkg::pdd_cmd_t                  push_cmd,
	output pdd_pkg::pdd_cfg_t                  cfg
);

	pdd_pkg::pdd_cfg_t cfg_q;
	logic              cfg_wr;

	assign in_stall  = q_stat.full;
	assign push      = in_valid && !q_stat.full;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_comb begin
		push_cmd.is_tick = (in_data.op == pdd_pkg::OP_TICK);
		push_cmd.shift   = (in_data.op == pdd_pkg::OP_SAMPLE) && in_data.sample_valid;
		push_cmd.error   = in_data.error_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain        <= pdd_pkg::RST_PROP_GAIN;
			cfg_q.integ_gain       <= pdd_pkg::RST_INTEG_GAIN;
			cfg_q.deriv_gain       <= pdd_pkg::RST_DERIV_GAIN;
			cfg_q.right_steer_gain <= pdd_pkg::RST_RSTEER_GAIN;
			cfg_q.right_base_gain  <= pdd_pkg::RST_RBASE_GAIN;
			cfg_q.left_steer_gain  <= pdd_pkg::RST_LSTEER_GAIN;
			cfg_q.left_base_gain   <= pdd_pkg::RST_LBASE_GAIN;
			cfg_q.base_speed       <= pdd_pkg::RST_BASE_SPEED;
		end else if (cfg_wr) begin
			case (cfg_index)
				pdd_pkg::CFG_PROP_GAIN:   cfg_q.prop_gain        <= cfg_data;
				pdd_pkg::CFG_INTEG_GAIN:  cfg_q.integ_gain       <= cfg_data;
				pdd_pkg::CFG_DERIV_GAIN:  cfg_q.deriv_gain       <= cfg_data;
				pdd_pkg::CFG_RSTEER_GAIN: cfg_q.right_steer_gain <= cfg_data;
				pdd_pkg::CFG_RBASE_GAIN:  cfg_q.right_base_gain  <= cfg_data;
				pdd_pkg::CFG_LSTEER_GAIN: cfg_q.left_steer_gain  <= cfg_data;
				pdd_pkg::CFG_LBASE_GAIN:  cfg_q.left_base_gain   <= cfg_data;
				pdd_pkg::CFG_BASE_SPEED:  cfg_q.base_speed       <= cfg_data[pdd_pkg::DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/pdd_queue.sv
// short command queue between the front end and the back end
`default_nettype none

module pdd_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  pdd_pkg::pdd_cmd_t    push_cmd,
	input  wire                  pop,
	output pdd_pkg::pdd_cmd_t    head,
	output pdd_pkg::pdd_qstat_t  q_stat
);

	pdd_pkg::pdd_cmd_t                entry_q [pdd_pkg::QUEUE_DEPTH];
	logic [pdd_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [pdd_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [pdd_pkg::QCNT_W-1:0]       count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == pdd_pkg::QCNT_W'(pdd_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == pdd_pkg::QPTR_W'(pdd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == pdd_pkg::QPTR_W'(pdd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/pdd_back.sv
// back end: pid multiply-accumulate sequencer, drive mixing, pwm slice counter, result register
`default_nettype none

module pdd_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pdd_pkg::pdd_cfg_t    cfg,
	input  pdd_pkg::pdd_qstat_t  q_stat,
	input  pdd_pkg::pdd_cmd_t    head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_stall,
	output pdd_pkg::pdd_out_t    out_data
);

	localparam int ACC_W = pdd_pkg::ACC_W;
	localparam int SLICE_W = pdd_pkg::SLICE_W;
	localparam int CMP_W = (SLICE_W > pdd_pkg::DUTY_W) ? SLICE_W + 1 : pdd_pkg::DUTY_W + 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIFF  = 4'd1;
	localparam logic [3:0] ST_P     = 4'd2;
	localparam logic [3:0] ST_I     = 4'd3;
	localparam logic [3:0] ST_D     = 4'd4;
	localparam logic [3:0] ST_SUM   = 4'd5;
	localparam logic [3:0] ST_CLAMP = 4'd6;
	localparam logic [3:0] ST_MR    = 4'd7;
	localparam logic [3:0] ST_RB    = 4'd8;
	localparam logic [3:0] ST_ML    = 4'd9;
	localparam logic [3:0] ST_RD    = 4'd10;
	localparam logic [3:0] ST_LB    = 4'd11;
	localparam logic [3:0] ST_LD    = 4'd12;

	logic [3:0]                     state_q;
	logic signed [15:0]             eo_q;
	logic signed [15:0]             ep_q;
	logic signed [15:0]             en_q;
	logic signed [15:0]             effort_q;
	logic [pdd_pkg::DUTY_W-1:0]     right_duty_q;
	logic [pdd_pkg::DUTY_W-1:0]     left_duty_q;
	logic [SLICE_W-1:0]             slice_q;
	logic signed [16:0]             d1_q;
	logic signed [17:0]             d2_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [ACC_W-1:0]        prod_q;
	logic                           out_valid_q;
	pdd_pkg::pdd_out_t              out_q;

	logic                           out_free;
	logic [SLICE_W-1:0]             slice_next;
	logic signed [15:0]             mul_a;
	logic signed [20:0]             mul_b;
	logic signed [36:0]             mul_p;
	logic signed [ACC_W-1:0]        mul_ext;
	logic signed [20:0]             base_term;
	logic [pdd_pkg::DUTY_W-1:0]     left_duty_new;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == ST_IDLE) && !q_stat.empty && out_free;

	assign slice_next = (slice_q == SLICE_W'(pdd_pkg::PWM_SLICES - 1)) ? '0 : slice_q + 1'b1;
	assign base_term  = $signed({1'b0, cfg.base_speed, 14'b0});
	assign mul_p      = mul_a * mul_b;
	assign mul_ext    = {{(ACC_W-37){mul_p[36]}}, mul_p};
	assign left_duty_new = pdd_pkg::make_duty(acc_q);

	always_comb begin
		mul_a = cfg.prop_gain;
		mul_b = {{4{d1_q[16]}}, d1_q};
		case (state_q)
			ST_I: begin
				mul_a = cfg.integ_gain;
				mul_b = {{5{en_q[15]}}, en_q};
			end
			ST_D: begin
				mul_a = cfg.deriv_gain;
				mul_b = {{3{d2_q[17]}}, d2_q};
			end
			ST_MR: begin
				mul_a = cfg.right_steer_gain;
				mul_b = {{5{effort_q[15]}}, effort_q};
			end
			ST_RB: begin
				mul_a = cfg.right_base_gain;
				mul_b = base_term;
			end
			ST_ML: begin
				mul_a = cfg.left_steer_gain;
				mul_b = {{5{effort_q[15]}}, effort_q};
			end
			ST_RD: begin
				mul_a = cfg.left_base_gain;
				mul_b = base_term;
			end
			default: begin
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_ext;
		case (state_q)
			ST_DIFF: begin
				d1_q  <= {en_q[15], en_q} - {ep_q[15], ep_q};
				d2_q  <= {{2{en_q[15]}}, en_q} - {ep_q[15], ep_q, 1'b0} + {{2{eo_q[15]}}, eo_q};
				acc_q <= {{(ACC_W-24){effort_q[15]}}, effort_q, 8'b0};
			end
			ST_I, ST_D, ST_SUM, ST_ML, ST_LB: begin
				acc_q <= acc_q + prod_q;
			end
			ST_RB: begin
				acc_q <= -prod_q;
			end
			ST_RD: begin
				acc_q <= prod_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			eo_q         <= '0;
			ep_q         <= '0;
			en_q         <= '0;
			effort_q     <= '0;
			right_duty_q <= '0;
			left_duty_q  <= '0;
			slice_q      <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.is_tick) begin
							slice_q           <= slice_next;
							out_valid_q       <= 1'b1;
							out_q.right_drive <= (CMP_W'(slice_next) < CMP_W'(right_duty_q));
							out_q.left_drive  <= (CMP_W'(slice_next) < CMP_W'(left_duty_q));
							out_q.right_level <= right_duty_q;
							out_q.left_level  <= left_duty_q;
							out_q.effort      <= effort_q;
						end else begin
							if (head.shift) begin
								eo_q <= ep_q;
								ep_q <= en_q;
								en_q <= head.error;
							end
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF:  state_q <= ST_P;
				ST_P:     state_q <= ST_I;
				ST_I:     state_q <= ST_D;
				ST_D:     state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_CLAMP;
				ST_CLAMP: begin
					effort_q <= pdd_pkg::clamp_effort(acc_q);
					state_q  <= ST_MR;
				end
				ST_MR:    state_q <= ST_RB;
				ST_RB:    state_q <= ST_ML;
				ST_ML:    state_q <= ST_RD;
				ST_RD: begin
					right_duty_q <= pdd_pkg::make_duty(acc_q);
					state_q      <= ST_LB;
				end
				ST_LB:    state_q <= ST_LD;
				ST_LD: begin
					left_duty_q       <= left_duty_new;
					out_valid_q       <= 1'b1;
					out_q.right_drive <= 1'b0;
					out_q.left_drive  <= 1'b0;
					out_q.right_level <= right_duty_q;
					out_q.left_level  <= left_duty_new;
					out_q.effort      <= effort_q;
					state_q           <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE) && !q_stat.empty)
		else $error("queue popped while busy or empty");

	a_effort_range: assert property (@(posedge clk) disable iff (!arst_n)
		(effort_q <= 16'sd16384) && (effort_q >= -16'sd16384))
		else $error("effort out of range");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.right_level <= 6'(pdd_pkg::DUTY_MAX))
			&& (out_q.left_level <= 6'(pdd_pkg::DUTY_MAX)))
		else $error("duty level out of range");

	a_sample_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD) |=> out_valid_q && !out_q.right_drive && !out_q.left_drive
			&& (out_q.left_level != '0) && (out_q.right_level != '0))
		else $error("sample result not delivered with lines low");

endmodule

`default_nettype wire

FILE: design/pid_differential_drive_pwm.sv
// top level of the pid line follower with differential drive pwm
// Two item kinds share one input channel. A tick item advances the pwm slice counter
// (wrapping at PWM_SLICES) and reports both motor line levels; it passes the queue, and its
// result is registered as it is popped, while the back end stays in its idle state.
// A sample item updates the error history and runs the incremental pid step and the
// right and left drive mixing through one shared 16x21 multiplier and a 40-bit
// accumulator; once popped it runs twelve sequencer steps, at the end of which its result
// (lines low, new duties, new effort) is registered. A four-entry queue behind the input
// lets items be taken while the back end works or the result waits to be taken.
// Configuration writes are always ready; indices above seven are ignored.
`default_nettype none

module pid_differential_drive_pwm (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  pdd_pkg::pdd_in_t                  in_data,
	output logic                              out_valid,
	input  wire                               out_stall,
	output pdd_pkg::pdd_out_t                 out_data,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [pdd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire  [pdd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pdd_pkg::pdd_qstat_t q_stat;
	pdd_pkg::pdd_cmd_t   push_cmd;
	pdd_pkg::pdd_cmd_t   head;
	pdd_pkg::pdd_cfg_t   cfg;
	logic                push;
	logic                pop;

	pdd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd),
		.cfg       (cfg)
	);

	pdd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	pdd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
